// ----- rtl/core/pfa_pkg.sv -----
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and constants for the paged frame allocator.
// Holds sizes, action and status codes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package pfa_pkg;

    // Sizes of the frame pool, process table and page lists.
    localparam int NUM_FRAMES = 256;
    localparam int FRAME_W    = $clog2(NUM_FRAMES);
    localparam int MAX_PROCS  = 16;
    localparam int SLOT_W     = $clog2(MAX_PROCS);
    localparam int MAX_PAGES  = 32;
    localparam int PAGE_W     = $clog2(MAX_PAGES);
    localparam int PT_ADDR_W  = SLOT_W + PAGE_W;
    localparam int PT_DEPTH   = MAX_PROCS * MAX_PAGES;

    // Field widths of the request, the response and the registers.
    localparam int COUNT_W = 9;
    localparam int TOTAL_W = 6;
    localparam int PID_W   = 16;
    localparam int LPAGE_W = 8;
    localparam int CFG_W   = 16;

    // Reset values and LFSR feedback.
    localparam logic [COUNT_W-1:0] FRAMES_RESET = COUNT_W'(NUM_FRAMES);
    localparam logic [15:0]        SEED_RESET   = 16'd44257;
    localparam logic [15:0]        LFSR_TAPS    = 16'hB400;

    // Configuration register indexes.
    localparam logic CFG_FRAMES = 1'b0;
    localparam logic CFG_SEED   = 1'b1;

    // Request actions.
    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_DEALLOC = 2'd1;
    localparam logic [1:0] ACT_WRITE   = 2'd2;
    localparam logic [1:0] ACT_READ    = 2'd3;

    // Response status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_FRAMES = 3'd1;
    localparam logic [2:0] ST_NO_PROC   = 3'd2;
    localparam logic [2:0] ST_BAD_PAGE  = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC_CHECK,
        S_ALLOC_DRAW,
        S_ALLOC_COMMIT,
        S_SCAN,
        S_SCAN_END,
        S_DEALLOC_READ,
        S_DEALLOC_FREE,
        S_DEALLOC_END,
        S_PAGE_WAIT,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;
        logic       alloc_start;
        logic       alloc_draw;
        logic       alloc_commit;
        logic       scan_step;
        logic       dealloc_start;
        logic       dealloc_free;
        logic       dealloc_end;
        logic       page_access;
        logic       res_load;
        logic [2:0] res_status;
        logic       out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] action;
        logic       too_few;
        logic       too_many;
        logic       no_slot;
        logic       draw_hit;
        logic       draw_last;
        logic       count_zero;
        logic       scan_last;
        logic       found;
        logic       pages_zero;
        logic       dealloc_last;
        logic       page_bad;
        logic       out_free;
    } stat_t;

    // Smallest all-ones mask that covers frame numbers below the pool size.
    function automatic logic [FRAME_W-1:0] draw_mask(input logic [COUNT_W-1:0] frames);
        logic [FRAME_W-1:0] m;
        logic [COUNT_W-1:0] top;
        top = frames - COUNT_W'(1);
        m   = top[FRAME_W-1:0];
        for (int i = 1; i < FRAME_W; i++)
        begin
            m = m | (m >> i);
        end
        return m;
    endfunction

endpackage

// ----- rtl/core/pfa_req_if.sv -----
// ----------------------------------------------------------------------------
// pfa_req_if: request channel of the paged frame allocator.
// Carries valid, ready and the request fields.
// ----------------------------------------------------------------------------
interface pfa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] process_id;
    logic [8:0]  page_count;
    logic [7:0]  logical_page;

    modport source (output valid, action, process_id, page_count, logical_page,
                    input ready);
    modport sink   (input valid, action, process_id, page_count, logical_page,
                    output ready);
endinterface

// ----- rtl/core/pfa_rsp_if.sv -----
// ----------------------------------------------------------------------------
// pfa_rsp_if: response channel of the paged frame allocator.
// Carries valid, ready and the response fields.
// ----------------------------------------------------------------------------
interface pfa_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] frame_number;
    logic       read_value;

    modport source (output valid, status, frame_number, read_value, input ready);
    modport sink   (input valid, status, frame_number, read_value, output ready);
endinterface

// ----- rtl/core/pfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// pfa_ctrl: request sequencer of the paged frame allocator.
// Steps each request through slot scan, frame draws or page walks, and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module pfa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  pfa_pkg::stat_t stat,
    output pfa_pkg::cmd_t  cmd
);
    import pfa_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.action == ACT_ALLOC)
                begin
                    state_next = S_ALLOC_CHECK;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    if (stat.scan_last)
                    begin
                        state_next = S_SCAN_END;
                    end
                end
            end
            S_ALLOC_CHECK:
            begin
                priority if (stat.too_few)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_NO_FRAMES;
                    state_next     = S_DONE;
                end
                else if (stat.too_many || stat.no_slot)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_FULL;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.alloc_start = 1'b1;
                    state_next      = stat.count_zero ? S_ALLOC_COMMIT : S_ALLOC_DRAW;
                end
            end
            S_ALLOC_DRAW:
            begin
                cmd.alloc_draw = 1'b1;
                if (stat.draw_hit && stat.draw_last)
                begin
                    state_next = S_ALLOC_COMMIT;
                end
            end
            S_ALLOC_COMMIT:
            begin
                cmd.alloc_commit = 1'b1;
                cmd.res_load     = 1'b1;
                cmd.res_status   = ST_OK;
                state_next       = S_DONE;
            end
            S_SCAN_END:
            begin
                priority if (!stat.found)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_NO_PROC;
                    state_next     = S_DONE;
                end
                else if (stat.action == ACT_DEALLOC)
                begin
                    cmd.dealloc_start = 1'b1;
                    state_next = stat.pages_zero ? S_DEALLOC_END : S_DEALLOC_READ;
                end
                else if (stat.page_bad)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_BAD_PAGE;
                    state_next     = S_DONE;
                end
                else
                begin
                    state_next = S_PAGE_WAIT;
                end
            end
            S_DEALLOC_READ:
            begin
                state_next = S_DEALLOC_FREE;
            end
            S_DEALLOC_FREE:
            begin
                cmd.dealloc_free = 1'b1;
                state_next = stat.dealloc_last ? S_DEALLOC_END : S_DEALLOC_READ;
            end
            S_DEALLOC_END:
            begin
                cmd.dealloc_end = 1'b1;
                cmd.res_load    = 1'b1;
                cmd.res_status  = ST_OK;
                state_next      = S_DONE;
            end
            S_PAGE_WAIT:
            begin
                cmd.page_access = 1'b1;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/pfa_datapath.sv -----
// ----------------------------------------------------------------------------
// pfa_datapath: state and arithmetic of the paged frame allocator.
// Holds the process table, page-frame memory, frame maps, LFSR, the
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module pfa_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [pfa_pkg::CFG_W-1:0] cfg_data,
    input  logic [1:0]               req_action,
    input  logic [15:0]              req_process_id,
    input  logic [8:0]               req_page_count,
    input  logic [7:0]               req_logical_page,
    input  pfa_pkg::cmd_t            cmd,
    output pfa_pkg::stat_t           stat,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [2:0]               out_status,
    output logic [7:0]               out_frame_number,
    output logic                     out_read_value
);
    import pfa_pkg::*;

    // Captured request.
    logic [1:0]          action_reg;
    logic [PID_W-1:0]    pid_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [LPAGE_W-1:0]  page_reg;

    // Process table.
    logic [MAX_PROCS-1:0] slot_valid_reg;
    logic [PID_W-1:0]     slot_pid_reg   [MAX_PROCS];
    logic [TOTAL_W-1:0]   slot_total_reg [MAX_PROCS];
    logic [15:0]          slot_age_reg   [MAX_PROCS];

    // Pool state.
    logic [NUM_FRAMES-1:0] free_map_reg;
    logic [NUM_FRAMES-1:0] written_map_reg;
    logic [COUNT_W-1:0]    free_total_reg;
    logic [COUNT_W-1:0]    frames_reg;
    logic [15:0]           lfsr_reg;
    logic [15:0]           seq_reg;

    // Sequencing.
    logic [SLOT_W-1:0]  scan_idx_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               found_reg;
    logic [15:0]        best_dist_reg;
    logic [TOTAL_W-1:0] k_reg;

    // Pending result and output register.
    logic [2:0]         res_status_reg;
    logic [FRAME_W-1:0] res_frame_reg;
    logic               res_rv_reg;
    logic               out_valid_reg;
    logic [2:0]         out_status_reg;
    logic [FRAME_W-1:0] out_frame_reg;
    logic               out_rv_reg;

    // Page-frame memory.
    logic [FRAME_W-1:0]   pt_mem [PT_DEPTH];
    logic [FRAME_W-1:0]   pt_rdata_reg;
    logic [PT_ADDR_W-1:0] pt_raddr;
    logic [PT_ADDR_W-1:0] pt_waddr;

    // Combinational helpers.
    logic [SLOT_W-1:0]  free_idx;
    logic               free_any;
    logic [15:0]        lfsr_next;
    logic [FRAME_W-1:0] draw_frame;
    logic               draw_hit;
    logic               cur_match;
    logic [15:0]        cur_dist;
    logic               better;
    logic [TOTAL_W-1:0] cur_total;
    logic [COUNT_W-1:0] cfg_frames;
    logic [15:0]        cfg_seed;
    logic               out_free;

    // Lowest unused process slot.
    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = MAX_PROCS - 1; i >= 0; i--)
        begin
            if (!slot_valid_reg[i])
            begin
                free_idx = SLOT_W'(i);
                free_any = 1'b1;
            end
        end
    end

    // LFSR step and candidate frame test.
    assign lfsr_next  = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_TAPS : 16'h0000);
    assign draw_frame = lfsr_next[FRAME_W-1:0] & draw_mask(frames_reg);
    assign draw_hit   = ({1'b0, draw_frame} < frames_reg) && free_map_reg[draw_frame];

    // Slot scan compare: matching pid with the newest age wins.
    assign cur_match = slot_valid_reg[scan_idx_reg] && (slot_pid_reg[scan_idx_reg] == pid_reg);
    assign cur_dist  = seq_reg - slot_age_reg[scan_idx_reg];
    assign better    = cur_match && (!found_reg || (cur_dist < best_dist_reg));
    assign cur_total = slot_total_reg[slot_reg];

    // Memory addresses.
    assign pt_raddr = {slot_reg, (action_reg == ACT_DEALLOC) ? k_reg[PAGE_W-1:0]
                                                             : page_reg[PAGE_W-1:0]};
    assign pt_waddr = {slot_reg, k_reg[PAGE_W-1:0]};

    // Configuration values after clamping.
    always_comb
    begin
        cfg_frames = cfg_data[COUNT_W-1:0];
        if (cfg_frames == '0)
        begin
            cfg_frames = COUNT_W'(1);
        end
        else if (cfg_frames > COUNT_W'(NUM_FRAMES))
        begin
            cfg_frames = COUNT_W'(NUM_FRAMES);
        end
        cfg_seed = (cfg_data == '0) ? 16'h0001 : cfg_data;
    end

    assign out_free = !out_valid_reg || out_ready;

    // Status to the controller.
    always_comb
    begin
        stat.action       = action_reg;
        stat.too_few      = count_reg > free_total_reg;
        stat.too_many     = count_reg > COUNT_W'(MAX_PAGES);
        stat.no_slot      = !free_any;
        stat.draw_hit     = draw_hit;
        stat.draw_last    = (COUNT_W'(k_reg) + COUNT_W'(1)) == count_reg;
        stat.count_zero   = count_reg == '0;
        stat.scan_last    = scan_idx_reg == SLOT_W'(MAX_PROCS - 1);
        stat.found        = found_reg;
        stat.pages_zero   = cur_total == '0;
        stat.dealloc_last = (k_reg + TOTAL_W'(1)) == cur_total;
        stat.page_bad     = (page_reg >= LPAGE_W'(cur_total))
                            || (page_reg >= LPAGE_W'(MAX_PAGES));
        stat.out_free     = out_free;
    end

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= req_action;
            pid_reg    <= req_process_id;
            count_reg  <= req_page_count;
            page_reg   <= req_logical_page;
        end
    end

    // Page-frame memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.alloc_draw && draw_hit)
        begin
            pt_mem[pt_waddr] <= draw_frame;
        end
        pt_rdata_reg <= pt_mem[pt_raddr];
    end

    // Process table payload.
    always_ff @(posedge clk)
    begin
        if (cmd.alloc_commit)
        begin
            slot_pid_reg[slot_reg]   <= pid_reg;
            slot_total_reg[slot_reg] <= count_reg[TOTAL_W-1:0];
            slot_age_reg[slot_reg]   <= seq_reg;
        end
    end

    // Sequencing payload and pending result.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            scan_idx_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            scan_idx_reg <= scan_idx_reg + SLOT_W'(1);
        end
        if (cmd.scan_step && better)
        begin
            slot_reg      <= scan_idx_reg;
            best_dist_reg <= cur_dist;
        end
        else if (cmd.alloc_start)
        begin
            slot_reg <= free_idx;
        end
        if (cmd.alloc_start || cmd.dealloc_start)
        begin
            k_reg <= '0;
        end
        else if ((cmd.alloc_draw && draw_hit) || cmd.dealloc_free)
        begin
            k_reg <= k_reg + TOTAL_W'(1);
        end
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_frame_reg  <= '0;
            res_rv_reg     <= 1'b0;
        end
        else if (cmd.page_access)
        begin
            res_status_reg <= ST_OK;
            res_frame_reg  <= pt_rdata_reg;
            res_rv_reg     <= (action_reg == ACT_READ) && written_map_reg[pt_rdata_reg];
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_frame_reg  <= res_frame_reg;
            out_rv_reg     <= res_rv_reg;
        end
    end

    // Control state: slot valid bits, maps, counters, LFSR, configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg  <= '0;
            free_map_reg    <= '1;
            written_map_reg <= '0;
            free_total_reg  <= FRAMES_RESET;
            frames_reg      <= FRAMES_RESET;
            lfsr_reg        <= SEED_RESET;
            seq_reg         <= '0;
            found_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            // The user must write configuration only while idle; the block itself does not enforce it.
            if (cfg_we && (cfg_index == CFG_FRAMES))
            begin
                frames_reg      <= cfg_frames;
                slot_valid_reg  <= '0;
                free_map_reg    <= '1;
                written_map_reg <= '0;
                free_total_reg  <= cfg_frames;
            end
            else if (cfg_we && (cfg_index == CFG_SEED))
            begin
                lfsr_reg <= cfg_seed;
            end
            else
            begin
                if (cmd.alloc_draw)
                begin
                    lfsr_reg <= lfsr_next;
                    if (draw_hit)
                    begin
                        free_map_reg[draw_frame] <= 1'b0;
                        free_total_reg           <= free_total_reg - COUNT_W'(1);
                    end
                end
                if (cmd.alloc_commit)
                begin
                    slot_valid_reg[slot_reg] <= 1'b1;
                    seq_reg                  <= seq_reg + 16'd1;
                end
                if (cmd.dealloc_free && !free_map_reg[pt_rdata_reg])
                begin
                    free_map_reg[pt_rdata_reg] <= 1'b1;
                    free_total_reg             <= free_total_reg + COUNT_W'(1);
                end
                if (cmd.dealloc_end)
                begin
                    slot_valid_reg[slot_reg] <= 1'b0;
                end
                if (cmd.page_access && (action_reg == ACT_WRITE))
                begin
                    written_map_reg[pt_rdata_reg] <= 1'b1;
                end
            end
            if (cmd.capture)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.scan_step && better)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_status       = out_status_reg;
    assign out_frame_number = out_frame_reg;
    assign out_read_value   = out_rv_reg;

endmodule

// ----- rtl/core/paged_frame_allocator_core.sv -----
// ----------------------------------------------------------------------------
// paged_frame_allocator_core: frame pool and page tables for 16 processes.
// Allocate checks limits, draws frames by LFSR, commits; others scan slots,
// then free each page or access one. One request at a time, via the output
// register. Reset frees all 256 frames at once, with no clearing pass.
// ----------------------------------------------------------------------------
module paged_frame_allocator_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [pfa_pkg::CFG_W-1:0] cfg_data,
    pfa_req_if.sink                   req,
    pfa_rsp_if.source                 rsp
);
    import pfa_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Request sequencer.
    pfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Tables, maps and output register.
    pfa_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .req_action       (req.action),
        .req_process_id   (req.process_id),
        .req_page_count   (req.page_count),
        .req_logical_page (req.logical_page),
        .cmd              (cmd),
        .stat             (stat),
        .out_valid        (rsp.valid),
        .out_ready        (rsp.ready),
        .out_status       (rsp.status),
        .out_frame_number (rsp.frame_number),
        .out_read_value   (rsp.read_value)
    );

endmodule

// ----- bench/tb_paged_frame_allocator_core.sv -----
// ----------------------------------------------------------------------------
// tb_paged_frame_allocator_core: self-checking bench for the frame allocator.
// Directed tests cover every action and status, duplicate process ids, zero
// page entries, a full process table and register clamping. Random phases
// then run mostly well-formed request streams under varied idling and stalls.
// Every response is checked against a cycle-free model of the frame pool.
// ----------------------------------------------------------------------------
module tb_paged_frame_allocator_core;
    import pfa_pkg::*;

    // One response as the model predicts it.
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] frame_number;
        logic       read_value;
    } alloc_rsp_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic                cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    pfa_req_if req_ch ();
    pfa_rsp_if rsp_ch ();

    paged_frame_allocator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Pool model: process table, page lists, frame maps and LFSR.
    bit          proc_valid [MAX_PROCS];
    logic [15:0] proc_pid   [MAX_PROCS];
    int          proc_pages [MAX_PROCS];
    logic [15:0] proc_age   [MAX_PROCS];
    logic [7:0]  page_map   [MAX_PROCS][MAX_PAGES];
    bit          frame_free [NUM_FRAMES];
    bit          frame_dirty[NUM_FRAMES];
    int          pool_size;
    int          free_count;
    logic [15:0] lfsr;
    logic [15:0] alloc_seq;

    alloc_rsp_t  pending_rsp[$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          stall_left;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run time limit.
    initial
    begin
        #200_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Clear the pool model, as a memory size write does.
    function automatic void pool_clear();
        for (int i = 0; i < MAX_PROCS; i++)
        begin
            proc_valid[i] = 1'b0;
        end
        for (int f = 0; f < NUM_FRAMES; f++)
        begin
            frame_free[f]  = 1'b1;
            frame_dirty[f] = 1'b0;
        end
        free_count = pool_size;
    endfunction

    // Newest valid slot holding a process id, or -1.
    function automatic int lookup_slot(logic [15:0] pid);
        int          best;
        logic [15:0] age_gap;
        logic [15:0] best_gap;
        best     = -1;
        best_gap = '0;
        for (int i = 0; i < MAX_PROCS; i++)
        begin
            if (proc_valid[i] && proc_pid[i] == pid)
            begin
                age_gap = alloc_seq - proc_age[i];
                if (best < 0 || age_gap < best_gap)
                begin
                    best     = i;
                    best_gap = age_gap;
                end
            end
        end
        return best;
    endfunction

    // One Galois LFSR step.
    function automatic logic [15:0] lfsr_step();
        logic lsb;
        lsb  = lfsr[0];
        lfsr = lfsr >> 1;
        if (lsb)
        begin
            lfsr = lfsr ^ LFSR_TAPS;
        end
        return lfsr;
    endfunction

    // Allocate frames for a new entry and return the status.
    function automatic logic [2:0] model_allocate(logic [15:0] pid, int count);
        int slot;
        int mask;
        int f;
        slot = -1;
        if (count > free_count)
        begin
            return ST_NO_FRAMES;
        end
        if (count > MAX_PAGES)
        begin
            return ST_FULL;
        end
        for (int i = MAX_PROCS - 1; i >= 0; i--)
        begin
            if (!proc_valid[i])
            begin
                slot = i;
            end
        end
        if (slot < 0)
        begin
            return ST_FULL;
        end
        mask = 1;
        while (mask < pool_size)
        begin
            mask = mask << 1;
        end
        mask = mask - 1;
        for (int k = 0; k < count; k++)
        begin
            for (int guard = 0; guard < 'h20000; guard++)
            begin
                f = int'(lfsr_step()) & mask;
                if (f < pool_size && frame_free[f])
                begin
                    frame_free[f]     = 1'b0;
                    free_count        = free_count - 1;
                    page_map[slot][k] = f[7:0];
                    break;
                end
            end
        end
        proc_valid[slot] = 1'b1;
        proc_pid[slot]   = pid;
        proc_pages[slot] = count;
        proc_age[slot]   = alloc_seq;
        alloc_seq        = alloc_seq + 16'd1;
        return ST_OK;
    endfunction

    // Expected response to one accepted request; updates the model.
    function automatic alloc_rsp_t predict_response(logic [1:0] action, logic [15:0] pid,
                                                    logic [8:0] count, logic [7:0] page);
        alloc_rsp_t r;
        int         slot;
        int         f;
        r = '0;
        case (action)
            ACT_ALLOC:
            begin
                r.status = model_allocate(pid, int'(count));
            end
            ACT_DEALLOC:
            begin
                slot = lookup_slot(pid);
                if (slot < 0)
                begin
                    r.status = ST_NO_PROC;
                end
                else
                begin
                    // Written bits of returned frames are kept.
                    for (int k = 0; k < proc_pages[slot]; k++)
                    begin
                        f = int'(page_map[slot][k]);
                        if (!frame_free[f])
                        begin
                            frame_free[f] = 1'b1;
                            free_count    = free_count + 1;
                        end
                    end
                    proc_valid[slot] = 1'b0;
                end
            end
            default:
            begin
                slot = lookup_slot(pid);
                if (slot < 0)
                begin
                    r.status = ST_NO_PROC;
                end
                else if (int'(page) >= proc_pages[slot])
                begin
                    r.status = ST_BAD_PAGE;
                end
                else
                begin
                    f = int'(page_map[slot][page[4:0]]);
                    if (action == ACT_WRITE)
                    begin
                        frame_dirty[f] = 1'b1;
                    end
                    else
                    begin
                        r.read_value = frame_dirty[f];
                    end
                    r.frame_number = f[7:0];
                end
            end
        endcase
        return r;
    endfunction

    // Offer one request, with random idle gaps, until it is accepted.
    task automatic send_request(logic [1:0] action, logic [15:0] pid,
                                logic [8:0] count, logic [7:0] page);
        alloc_rsp_t expected;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.action       <= action;
        req_ch.process_id   <= pid;
        req_ch.page_count   <= count;
        req_ch.logical_page <= page;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        expected    = predict_response(action, pid, count, page);
        pending_rsp = {pending_rsp, expected};
    endtask

    // Lower valid and wait until every response has arrived and the block settles.
    task automatic drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);
    endtask

    // Register write while the block is idle.
    task automatic write_register(logic index, logic [CFG_W-1:0] value);
        int v;
        drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (index == CFG_FRAMES)
        begin
            v = int'(value[8:0]);
            pool_size = (v < 1) ? 1 : (v > NUM_FRAMES) ? NUM_FRAMES : v;
            pool_clear();
        end
        else
        begin
            lfsr = (value == '0) ? 16'd1 : value;
        end
    endtask

    // Response ready with random stalls and an optional long hold.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left   <= stall_left - 1;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Compare each accepted response with the oldest prediction.
    always @(posedge clk)
    begin
        alloc_rsp_t want;
        alloc_rsp_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = {rsp_ch.status, rsp_ch.frame_number, rsp_ch.read_value};
            if (pending_rsp.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                begin
                    $display("Unexpected response: status %0d frame %0d value %0d",
                             got.status, got.frame_number, got.read_value);
                end
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (got !== want)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                    begin
                        $display("Mismatch: expected status %0d frame %0d value %0d, got %0d %0d %0d",
                                 want.status, want.frame_number, want.read_value,
                                 got.status, got.frame_number, got.read_value);
                    end
                end
            end
        end
    end

    // Every action on one process, zero pages and the page range limits.
    task automatic test_page_access();
        send_request(ACT_ALLOC, 16'h0000, 9'd32, 8'd0);
        send_request(ACT_WRITE, 16'h0000, 9'd0, 8'd31);
        send_request(ACT_READ, 16'h0000, 9'd0, 8'd31);
        send_request(ACT_READ, 16'h0000, 9'd0, 8'd0);
        send_request(ACT_READ, 16'h0000, 9'd0, 8'd32);
        send_request(ACT_WRITE, 16'h0000, 9'd0, 8'd255);
        send_request(ACT_ALLOC, 16'hFFFF, 9'd0, 8'd0);
        send_request(ACT_READ, 16'hFFFF, 9'd0, 8'd0);
        send_request(ACT_DEALLOC, 16'h0000, 9'd0, 8'd0);
        send_request(ACT_READ, 16'h0000, 9'd0, 8'd0);
        send_request(ACT_DEALLOC, 16'h0000, 9'd0, 8'd0);
        send_request(ACT_DEALLOC, 16'hFFFF, 9'd0, 8'd0);
    endtask

    // Too many pages and the newest of duplicate ids.
    task automatic test_alloc_limits();
        send_request(ACT_ALLOC, 16'h1234, 9'd256, 8'd0);
        send_request(ACT_ALLOC, 16'h1234, 9'd33, 8'd0);
        send_request(ACT_ALLOC, 16'h0007, 9'd2, 8'd0);
        send_request(ACT_ALLOC, 16'h0007, 9'd5, 8'd0);
        send_request(ACT_WRITE, 16'h0007, 9'd0, 8'd4);
        send_request(ACT_READ, 16'h0007, 9'd0, 8'd4);
        send_request(ACT_DEALLOC, 16'h0007, 9'd0, 8'd0);
        send_request(ACT_READ, 16'h0007, 9'd0, 8'd4);
        send_request(ACT_READ, 16'h0007, 9'd0, 8'd1);
        send_request(ACT_DEALLOC, 16'h0007, 9'd0, 8'd0);
    endtask

    // Fill the process table, overflow it, then empty it.
    task automatic test_table_full();
        for (int i = 0; i <= MAX_PROCS; i++)
        begin
            send_request(ACT_ALLOC, 16'(i * 4099), 9'd1, 8'd0);
        end
        for (int i = 0; i <= MAX_PROCS; i++)
        begin
            send_request(ACT_DEALLOC, 16'(i * 4099), 9'd0, 8'd0);
        end
    endtask

    // Pool of a single frame, with clamped register values.
    task automatic test_register_extremes();
        write_register(CFG_FRAMES, 16'd0);
        write_register(CFG_SEED, 16'd0);
        send_request(ACT_ALLOC, 16'h00AA, 9'd1, 8'd0);
        send_request(ACT_ALLOC, 16'h00AB, 9'd1, 8'd0);
        send_request(ACT_WRITE, 16'h00AA, 9'd0, 8'd0);
        send_request(ACT_READ, 16'h00AA, 9'd0, 8'd0);
        write_register(CFG_FRAMES, 16'd300);
        write_register(CFG_SEED, 16'hFFFF);
        send_request(ACT_READ, 16'h00AA, 9'd0, 8'd0);
        send_request(ACT_ALLOC, 16'h00AA, 9'd256, 8'd0);
    endtask

    // Random stream, mostly aimed at live processes and pages within range.
    task automatic run_random(int count, int send_pct, int recv_pct, bit with_stalls);
        int          live[$];
        int          pick;
        int          slot;
        logic [1:0]  action;
        logic [15:0] pid;
        logic [8:0]  pages;
        logic [7:0]  page;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int n = 0; n < count; n++)
        begin
            live.delete();
            for (int i = 0; i < MAX_PROCS; i++)
            begin
                if (proc_valid[i])
                begin
                    live = {live, i};
                end
            end
            pick  = $urandom_range(99);
            pid   = 16'($urandom);
            pages = 9'($urandom_range(6));
            page  = 8'($urandom_range(255));
            slot  = -1;
            if (live.size() != 0 && $urandom_range(99) < 85)
            begin
                slot = live[$urandom_range(live.size() - 1)];
                pid  = proc_pid[slot];
            end
            if (pick < 30)
            begin
                action = ACT_ALLOC;
                if ($urandom_range(9) == 0)
                begin
                    pages = 9'($urandom_range(256));
                end
                else if ($urandom_range(4) == 0)
                begin
                    pages = 9'($urandom_range(40));
                end
            end
            else if (pick < 48)
            begin
                action = ACT_DEALLOC;
            end
            else
            begin
                action = (pick < 74) ? ACT_WRITE : ACT_READ;
                if (slot >= 0 && proc_pages[slot] > 0 && $urandom_range(9) != 0)
                begin
                    page = 8'($urandom_range(proc_pages[slot] - 1));
                end
            end
            send_request(action, pid, pages, page);
            // Long response hold while requests keep coming.
            if (with_stalls && n == count / 3)
            begin
                stall_left = 400;
            end
            // Sender pause until all responses are in.
            if (with_stalls && n == (2 * count) / 3)
            begin
                drain();
            end
        end
    endtask

    // Test sequence.
    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_FRAMES;
        cfg_data            = '0;
        req_ch.valid        = 1'b0;
        req_ch.action       = ACT_ALLOC;
        req_ch.process_id   = '0;
        req_ch.page_count   = '0;
        req_ch.logical_page = '0;
        rsp_ch.ready        = 1'b0;
        mismatches          = 0;
        send_idle_pct       = 0;
        recv_idle_pct       = 0;
        stall_left          = 0;
        pool_size           = int'(FRAMES_RESET);
        lfsr                = SEED_RESET;
        alloc_seq           = '0;
        pool_clear();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_page_access();
        test_alloc_limits();
        test_table_full();
        test_register_extremes();

        write_register(CFG_FRAMES, 16'd16);
        write_register(CFG_SEED, 16'd1);
        run_random(460, 36, 60, 1'b1);
        write_register(CFG_FRAMES, 16'd256);
        write_register(CFG_SEED, 16'($urandom_range(65535, 1)));
        run_random(460, 60, 36, 1'b0);
        write_register(CFG_FRAMES, 16'd100);
        write_register(CFG_SEED, 16'hACE1);
        run_random(460, 0, 0, 1'b0);
        drain();

        if (mismatches == 0 && pending_rsp.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/core/pfa_pkg.sv
rtl/core/pfa_req_if.sv
rtl/core/pfa_rsp_if.sv
rtl/core/pfa_ctrl.sv
rtl/core/pfa_datapath.sv
rtl/core/paged_frame_allocator_core.sv
bench/tb_paged_frame_allocator_core.sv
